### design/fnu_pkg.sv
// Shared widths, constants and beat types for the face normal unit.
package fnu_pkg;

  // Port widths fixed by the interface
  localparam int IN_W            = 16;
  localparam int OUT_W           = 16;
  localparam int COORD_WIDTH_DEF = 16;

  // Normalised magnitude: largest component lands in [2^29, 2^30)
  localparam int MAG_W    = 30;
  localparam int NORM_POS = MAG_W - 1;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = SQ_W + 2;

  // Integer square root of the sum of squares
  localparam int ROOT_W = SUM_W / 2;

  // Rounded divide: quotient up to one in Q1.14
  localparam int Q_W     = 15;
  localparam int FRAC_SH = 15;
  localparam int DIV_W   = ROOT_W + 1;
  localparam int NUM_W   = MAG_W + FRAC_SH + 1;

  localparam logic [Q_W-1:0] ONE_Q14 = Q_W'(16384);

  // Per-beat flags that ride along with the arithmetic
  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } fnu_flags_t;

  // Side data carried through the square root pipeline
  typedef struct packed {
    logic [2:0][MAG_W-1:0] m;
    fnu_flags_t            flags;
  } fnu_sq_tag_t;

endpackage

### design/fnu_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module fnu_isqrt
  import fnu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [SUM_W-1:0]   in_sum,
  input  fnu_sq_tag_t        in_tag,
  output logic               out_vld,
  output logic [ROOT_W-1:0]  out_root,
  output fnu_sq_tag_t        out_tag
);

  logic [SUM_W-1:0]  rem_r [ROOT_W];
  logic [SUM_W-1:0]  rem_nxt [ROOT_W];
  logic [ROOT_W-1:0] q_r [ROOT_W];
  logic [ROOT_W-1:0] q_nxt [ROOT_W];
  fnu_sq_tag_t       tag_r [ROOT_W];
  logic              vld_r [ROOT_W];

  // Restoring square root: stage k settles root bit ROOT_W-1-k
  always_comb begin
    logic [SUM_W-1:0]  r_in;
    logic [SUM_W-1:0]  trial;
    logic [ROOT_W-1:0] q_in;
    for (int k = 0; k < ROOT_W; k++) begin
      r_in  = (k == 0) ? in_sum : rem_r[(k == 0) ? 0 : k - 1];
      q_in  = (k == 0) ? '0 : q_r[(k == 0) ? 0 : k - 1];
      trial = (SUM_W'(q_in) << (ROOT_W - k)) | (SUM_W'(1) << (2 * (ROOT_W - 1 - k)));
      if (r_in >= trial) begin
        rem_nxt[k] = r_in - trial;
        q_nxt[k]   = q_in | (ROOT_W'(1) << (ROOT_W - 1 - k));
      end else begin
        rem_nxt[k] = r_in;
        q_nxt[k]   = q_in;
      end
    end
  end

  // Data stages
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_W; k++) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
        tag_r[k] <= (k == 0) ? in_tag : tag_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ROOT_W; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < ROOT_W; k++) begin
        vld_r[k] <= (k == 0) ? in_vld : vld_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = q_r[ROOT_W-1];
  assign out_tag  = tag_r[ROOT_W-1];

endmodule

### design/fnu_div.sv
// Pipelined rounded divide of three magnitudes by twice the root.
module fnu_div
  import fnu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [ROOT_W-1:0]     in_root,
  input  fnu_sq_tag_t           in_tag,
  output logic                  out_vld,
  output logic [2:0][Q_W-1:0]   out_q,
  output fnu_flags_t            out_flags
);

  // Pre stage: numerators m*2^15 + L, divisor 2L
  logic [NUM_W-1:0] num_r [3];
  logic [DIV_W-1:0] dpre_r;
  fnu_flags_t       fpre_r;
  logic             vpre_r;

  logic [NUM_W-1:0] rem_r [Q_W][3];
  logic [NUM_W-1:0] rem_nxt [Q_W][3];
  logic [Q_W-1:0]   q_r [Q_W][3];
  logic [Q_W-1:0]   q_nxt [Q_W][3];
  logic [DIV_W-1:0] d_r [Q_W];
  fnu_flags_t       f_r [Q_W];
  logic             vld_r [Q_W];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        num_r[l] <= {1'b0, in_tag.m[l], {FRAC_SH{1'b0}}} + NUM_W'(in_root);
      end
      dpre_r <= {in_root, 1'b0};
      fpre_r <= in_tag.flags;
    end
  end

  // Restoring divide: stage k settles quotient bit Q_W-1-k
  always_comb begin
    logic [NUM_W-1:0] r_in;
    logic [NUM_W-1:0] trial;
    logic [Q_W-1:0]   q_in;
    logic [DIV_W-1:0] d_in;
    for (int k = 0; k < Q_W; k++) begin
      d_in  = (k == 0) ? dpre_r : d_r[(k == 0) ? 0 : k - 1];
      trial = NUM_W'(d_in) << (Q_W - 1 - k);
      for (int l = 0; l < 3; l++) begin
        r_in = (k == 0) ? num_r[l] : rem_r[(k == 0) ? 0 : k - 1][l];
        q_in = (k == 0) ? '0 : q_r[(k == 0) ? 0 : k - 1][l];
        if (r_in >= trial) begin
          rem_nxt[k][l] = r_in - trial;
          q_nxt[k][l]   = q_in | (Q_W'(1) << (Q_W - 1 - k));
        end else begin
          rem_nxt[k][l] = r_in;
          q_nxt[k][l]   = q_in;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < Q_W; k++) begin
        for (int l = 0; l < 3; l++) begin
          rem_r[k][l] <= rem_nxt[k][l];
          q_r[k][l]   <= q_nxt[k][l];
        end
        d_r[k] <= (k == 0) ? dpre_r : d_r[(k == 0) ? 0 : k - 1];
        f_r[k] <= (k == 0) ? fpre_r : f_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpre_r <= 1'b0;
      for (int k = 0; k < Q_W; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vpre_r <= in_vld;
      for (int k = 0; k < Q_W; k++) begin
        vld_r[k] <= (k == 0) ? vpre_r : vld_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign out_vld   = vld_r[Q_W-1];
  assign out_q[0]  = q_r[Q_W-1][0];
  assign out_q[1]  = q_r[Q_W-1][1];
  assign out_q[2]  = q_r[Q_W-1][2];
  assign out_flags = f_r[Q_W-1];

endmodule

### design/face_normal_unit_core.sv
// Top level of the face normal unit: cross product, normalise, root, divide.
//
// Input channel (in_*): one triangle per beat, three vertices in signed Q8.8,
// accepted when in_valid is high and in_stall is low. Only the low
// COORD_WIDTH bits of each coordinate are used.
// Output channel (out_*): the unit face normal in signed Q1.14 plus a flag
// for a degenerate triangle, which gives (1,0,0). A beat leaves when
// out_valid is high and out_stall is low.
// From accept to out_valid a triangle passes 8 front stages (diff,
// multiply, cross, magnitude, leading one, shift, square, sum), 31 square
// root stages at one root bit each, 16 divide stages (numerator set-up and
// one quotient bit each) and the output register.
// One triangle per cycle while not stalled; every stage is fully pipelined.
// A synchronous active-low reset clears every valid bit; data registers
// are not reset. While a result waits with out_stall high, the whole
// pipeline holds and in_stall is raised; nothing is lost or repeated.
module face_normal_unit_core
  import fnu_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [IN_W-1:0]  in_a_x,
  input  logic signed [IN_W-1:0]  in_a_y,
  input  logic signed [IN_W-1:0]  in_a_z,
  input  logic signed [IN_W-1:0]  in_b_x,
  input  logic signed [IN_W-1:0]  in_b_y,
  input  logic signed [IN_W-1:0]  in_b_z,
  input  logic signed [IN_W-1:0]  in_c_x,
  input  logic signed [IN_W-1:0]  in_c_y,
  input  logic signed [IN_W-1:0]  in_c_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_normal_x,
  output logic signed [OUT_W-1:0] out_normal_y,
  output logic signed [OUT_W-1:0] out_normal_z,
  output logic                    out_degenerate
);

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 1;
  localparam int PW  = 2 * CW + 2;
  localparam int NCW = 2 * CW + 3;
  localparam int XW  = (CW > IN_W) ? CW : IN_W;
  localparam int SW  = (NCW > MAG_W) ? NCW : MAG_W;
  localparam int LW  = $clog2(NCW);

  logic adv;

  // Whole pipeline moves unless a finished beat is held
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Coordinate extraction
  logic [IN_W-1:0]      raw [9];
  logic signed [CW-1:0] crd [9];

  assign raw[0] = in_a_x;
  assign raw[1] = in_a_y;
  assign raw[2] = in_a_z;
  assign raw[3] = in_b_x;
  assign raw[4] = in_b_y;
  assign raw[5] = in_b_z;
  assign raw[6] = in_c_x;
  assign raw[7] = in_c_y;
  assign raw[8] = in_c_z;

  for (genvar i = 0; i < 9; i++) begin : g_crd
    logic [XW-1:0] ext;
    assign ext    = XW'(raw[i]);
    assign crd[i] = $signed(ext[CW-1:0]);
  end

  // Stage registers
  logic signed [DW-1:0]  d1_r [3];
  logic signed [DW-1:0]  d2_r [3];
  logic signed [PW-1:0]  p_r [6];
  logic signed [NCW-1:0] n_r [3];
  logic [NCW-1:0]        mag4_r [3];
  logic [NCW-1:0]        big_r;
  logic [NCW-1:0]        mag5_r [3];
  logic [LW-1:0]         pos_r;
  logic [MAG_W-1:0]      m6_r [3];
  logic [SQ_W-1:0]       sq_r [3];
  logic [SUM_W-1:0]      sum_r;
  fnu_sq_tag_t           tag8_r;
  fnu_flags_t            f4_r, f5_r, f6_r, f7_r;
  logic [MAG_W-1:0]      m7_r [3];
  logic [8:1]            v_r;

  // Magnitude, sign and largest component
  logic [NCW-1:0] mag_nxt [3];
  logic [NCW-1:0] big_nxt;
  fnu_flags_t     f_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i]   = n_r[i][NCW-1] ? NCW'(-n_r[i]) : NCW'(n_r[i]);
      f_nxt.neg[i] = n_r[i][NCW-1];
    end
    f_nxt.degen = (n_r[0] == '0) && (n_r[1] == '0) && (n_r[2] == '0);
    big_nxt = mag_nxt[0];
    if (mag_nxt[1] > big_nxt) big_nxt = mag_nxt[1];
    if (mag_nxt[2] > big_nxt) big_nxt = mag_nxt[2];
  end

  // Leading one of the largest magnitude
  logic [LW-1:0] pos_nxt;

  always_comb begin
    pos_nxt = '0;
    for (int b = 0; b < NCW; b++) begin
      if (big_r[b]) pos_nxt = LW'(b);
    end
  end

  // Common shift to bring the leading one to bit NORM_POS
  logic [MAG_W-1:0] m_nxt [3];

  always_comb begin
    logic [SW-1:0] ext;
    for (int i = 0; i < 3; i++) begin
      ext = SW'(mag5_r[i]);
      if (pos_r >= LW'(NORM_POS)) begin
        m_nxt[i] = MAG_W'(ext >> (pos_r - LW'(NORM_POS)));
      end else begin
        m_nxt[i] = MAG_W'(ext << (LW'(NORM_POS) - pos_r));
      end
    end
  end

  // Front pipeline data
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i] <= DW'(crd[i]) - DW'(crd[3+i]);
        d2_r[i] <= DW'(crd[3+i]) - DW'(crd[6+i]);
      end
      p_r[0] <= d1_r[1] * d2_r[2];
      p_r[1] <= d1_r[2] * d2_r[1];
      p_r[2] <= d1_r[2] * d2_r[0];
      p_r[3] <= d1_r[0] * d2_r[2];
      p_r[4] <= d1_r[0] * d2_r[1];
      p_r[5] <= d1_r[1] * d2_r[0];
      for (int i = 0; i < 3; i++) begin
        n_r[i]    <= NCW'(p_r[2*i]) - NCW'(p_r[2*i+1]);
        mag4_r[i] <= mag_nxt[i];
        mag5_r[i] <= mag4_r[i];
        m6_r[i]   <= m_nxt[i];
        sq_r[i]   <= m6_r[i] * m6_r[i];
        m7_r[i]   <= m6_r[i];
      end
      big_r <= big_nxt;
      pos_r <= pos_nxt;
      f4_r  <= f_nxt;
      f5_r  <= f4_r;
      f6_r  <= f5_r;
      f7_r  <= f6_r;
      sum_r <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
      for (int i = 0; i < 3; i++) tag8_r.m[i] <= m7_r[i];
      tag8_r.flags <= f7_r;
    end
  end

  // Front valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[7:1], in_valid};
    end
  end

  // Square root of the sum of squares
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  fnu_sq_tag_t       sq_tag;

  fnu_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (v_r[8]),
    .in_sum   (sum_r),
    .in_tag   (tag8_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_tag  (sq_tag)
  );

  // Rounded divide of each magnitude by the root
  logic                div_vld;
  logic [2:0][Q_W-1:0] div_q;
  fnu_flags_t          div_flags;

  fnu_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_vld    (sq_vld),
    .in_root   (sq_root),
    .in_tag    (sq_tag),
    .out_vld   (div_vld),
    .out_q     (div_q),
    .out_flags (div_flags)
  );

  // Clamp, sign and degenerate fallback
  logic [OUT_W-1:0] nrm_nxt [3];

  always_comb begin
    logic [Q_W-1:0]   qc;
    logic [OUT_W-1:0] mg;
    for (int i = 0; i < 3; i++) begin
      qc = (div_q[i] > ONE_Q14) ? ONE_Q14 : div_q[i];
      mg = OUT_W'(qc);
      nrm_nxt[i] = div_flags.neg[i] ? (~mg + 1'b1) : mg;
    end
    if (div_flags.degen) begin
      nrm_nxt[0] = OUT_W'(ONE_Q14);
      nrm_nxt[1] = '0;
      nrm_nxt[2] = '0;
    end
  end

  // Output register
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] nx_r, ny_r, nz_r;
  logic                    degen_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      nx_r    <= $signed(nrm_nxt[0]);
      ny_r    <= $signed(nrm_nxt[1]);
      nz_r    <= $signed(nrm_nxt[2]);
      degen_r <= div_flags.degen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_vld;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_normal_x   = nx_r;
  assign out_normal_y   = ny_r;
  assign out_normal_z   = nz_r;
  assign out_degenerate = degen_r;

endmodule
